// ----- rtl/month_calendar_grid_generator_assert.svh -----
// Assertion macros for the calendar grid generator.
`ifndef MONTH_CALENDAR_GRID_GENERATOR_ASSERT_SVH
`define MONTH_CALENDAR_GRID_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MCGG_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

`define MCGG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`else

`define MCGG_ASSERT_SAME(lbl, clk, rstn, ante, cons)

`define MCGG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/mcgg_pkg.sv -----
package mcgg_pkg;

  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int CELL_W  = 6;
  localparam int DAY_W   = 5;
  localparam int REL_W   = 2;
  localparam int COL_W   = 3;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

  localparam int YEAR_OFFSET = 400;
  localparam int RECIP100    = 5243;
  localparam int RECIP7      = 37450;

  localparam logic [COL_W-1:0] LAST_COL = 3'd6;

  localparam logic [REL_W-1:0] REL_PREV = 2'd0;
  localparam logic [REL_W-1:0] REL_CUR  = 2'd1;
  localparam logic [REL_W-1:0] REL_NEXT = 2'd2;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_DIVYY,
    FR_DIVY,
    FR_MOD7,
    FR_FIN,
    FR_PUSH
  } front_state_t;

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] prev_month;
    logic [YEAR_W-1:0]  prev_year;
    logic [MONTH_W-1:0] next_month;
    logic [YEAR_W-1:0]  next_year;
    logic [COL_W-1:0]   col;
    logic [DAY_W-1:0]   len;
    logic [DAY_W-1:0]   prev_len;
  } job_t;

  function automatic logic [2:0] sak_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] r;
    case (m)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd3;
      4'd2:    r = 3'd2;
      4'd3:    r = 3'd5;
      4'd4:    r = 3'd0;
      4'd5:    r = 3'd3;
      4'd6:    r = 3'd5;
      4'd7:    r = 3'd1;
      4'd8:    r = 3'd4;
      4'd9:    r = 3'd6;
      4'd10:   r = 3'd2;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1:                   r = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
      default:                r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mcgg_front.sv -----
module mcgg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mcgg_pkg::MONTH_W-1:0]  in_month,
  input  logic [mcgg_pkg::YEAR_W-1:0]   in_year,
  output logic                          push_valid,
  input  logic                          push_ready,
  output mcgg_pkg::job_t                push_job
);
  import mcgg_pkg::*;

  front_state_t state_r, state_nxt;

  logic [MONTH_W-1:0] m_r;
  logic [YEAR_W-1:0]  y_r;
  logic [14:0]        yy_r;
  logic [7:0]         q100yy_r;
  logic [7:0]         q100y_r;
  logic [14:0]        s_r;
  logic [11:0]        q7_r;
  job_t               job_r, job_nxt;

  logic [MONTH_W-1:0] m_sat;
  logic [14:0]        yy_in;
  logic [14:0]        mul_a;
  logic [15:0]        mul_b;
  logic [30:0]        prod;
  logic [14:0]        s_nxt;
  logic [14:0]        t7;
  logic [14:0]        sun0_full;
  logic [2:0]         sun0;
  logic [YEAR_W-1:0]  h100;
  logic [YEAR_W-1:0]  rem100;
  logic               leap;

  assign m_sat = (in_month > MONTH_DEC) ? MONTH_DEC : in_month;
  assign yy_in = {1'b0, in_year} + 15'(YEAR_OFFSET) - {14'b0, (m_sat <= MONTH_FEB)};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE:  if (in_tvalid) state_nxt = FR_DIVYY;
      FR_DIVYY: state_nxt = FR_DIVY;
      FR_DIVY:  state_nxt = FR_MOD7;
      FR_MOD7:  state_nxt = FR_FIN;
      FR_FIN:   state_nxt = FR_PUSH;
      FR_PUSH:  if (push_ready) state_nxt = FR_IDLE;
      default:  state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    push_valid = 1'b0;
    mul_a      = yy_r;
    mul_b      = 16'(RECIP100);
    case (state_r)
      FR_IDLE: in_tready = 1'b1;
      FR_DIVY: mul_a = {1'b0, y_r};
      FR_MOD7: begin
        mul_a = s_r;
        mul_b = 16'(RECIP7);
      end
      FR_PUSH: push_valid = 1'b1;
      default: ;
    endcase
  end

  assign prod = {16'b0, mul_a} * {15'b0, mul_b};

  assign s_nxt = yy_r + {2'b0, yy_r[14:2]} - {7'b0, q100yy_r} + {9'b0, q100yy_r[7:2]}
               + {12'b0, sak_offset(m_r)} + 15'd1;

  assign t7        = {q7_r, 3'b0} - {3'b0, q7_r};
  assign sun0_full = s_r - t7;
  assign sun0      = sun0_full[2:0];

  assign h100   = {q100y_r, 6'b0} + {1'b0, q100y_r, 5'b0} + {4'b0, q100y_r, 2'b0};
  assign rem100 = y_r - h100;
  assign leap   = (rem100 == '0) ? (q100y_r[1:0] == 2'b00) : (y_r[1:0] == 2'b00);

  always_comb begin
    job_nxt.month      = m_r;
    job_nxt.year       = y_r;
    job_nxt.prev_month = (m_r == MONTH_JAN) ? MONTH_DEC : m_r - 4'd1;
    job_nxt.prev_year  = (m_r == MONTH_JAN) ? y_r - 14'd1 : y_r;
    job_nxt.next_month = (m_r == MONTH_DEC) ? MONTH_JAN : m_r + 4'd1;
    job_nxt.next_year  = (m_r == MONTH_DEC) ? y_r + 14'd1 : y_r;
    job_nxt.col        = (sun0 == 3'd0) ? LAST_COL : sun0 - 3'd1;
    job_nxt.len        = month_len(m_r, leap);
    job_nxt.prev_len   = month_len(job_nxt.prev_month, leap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FR_IDLE && in_tvalid) begin
      m_r  <= m_sat;
      y_r  <= in_year;
      yy_r <= yy_in;
    end
    if (state_r == FR_DIVYY) begin
      q100yy_r <= prod[26:19];
    end
    if (state_r == FR_DIVY) begin
      q100y_r <= prod[26:19];
      s_r     <= s_nxt;
    end
    if (state_r == FR_MOD7) begin
      q7_r <= prod[29:18];
    end
    if (state_r == FR_FIN) begin
      job_r <= job_nxt;
    end
  end

  assign push_job = job_r;

endmodule

// ----- rtl/mcgg_queue.sv -----
`include "month_calendar_grid_generator_assert.svh"

module mcgg_queue #(
  parameter int DEPTH = mcgg_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  mcgg_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mcgg_pkg::job_t pop_job
);
  import mcgg_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t            slots [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_job;
    end
  end

  `MCGG_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `MCGG_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + CW'(1))
  `MCGG_ASSERT_SAME(a_ptr_sync, clk, rst_n, count_r == '0 || count_r == CW'(DEPTH), wr_ptr_r == rd_ptr_r)

endmodule

// ----- rtl/mcgg_back.sv -----
`include "month_calendar_grid_generator_assert.svh"

module mcgg_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             job_valid,
  output logic                             job_ready,
  input  mcgg_pkg::job_t                   job,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mcgg_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [mcgg_pkg::REL_W-1:0]       out_tuser,
  output logic                             out_tlast
);
  import mcgg_pkg::*;

  logic               busy_r;
  job_t               job_r;
  logic [CELL_W-1:0]  n_r;
  logic [COL_W-1:0]   wk_r;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [REL_W-1:0]   rel_r, rel_nxt;

  logic               out_tvalid_r;
  logic [CELL_W-1:0]  o_idx_r;
  logic [DAY_W-1:0]   o_day_r;
  logic [MONTH_W-1:0] o_month_r;
  logic [YEAR_W-1:0]  o_year_r;
  logic [REL_W-1:0]   o_rel_r;
  logic               o_last_r;

  logic               load, emit, is_last;
  logic [MONTH_W-1:0] cell_month;
  logic [YEAR_W-1:0]  cell_year;

  assign job_ready = !busy_r;
  assign load      = !busy_r && job_valid;
  assign emit      = busy_r && (!out_tvalid_r || out_tready);

  always_comb begin
    case (rel_r)
      REL_PREV: begin
        cell_month = job_r.prev_month;
        cell_year  = job_r.prev_year;
      end
      REL_CUR: begin
        cell_month = job_r.month;
        cell_year  = job_r.year;
      end
      default: begin
        cell_month = job_r.next_month;
        cell_year  = job_r.next_year;
      end
    endcase
  end

  assign is_last = (wk_r == LAST_COL)
                && ((rel_r == REL_CUR && day_r == job_r.len) || rel_r == REL_NEXT);

  always_comb begin
    day_nxt = day_r + DAY_W'(1);
    rel_nxt = rel_r;
    case (rel_r)
      REL_PREV: begin
        if (day_r == job_r.prev_len) begin
          day_nxt = DAY_W'(1);
          rel_nxt = REL_CUR;
        end
      end
      REL_CUR: begin
        if (day_r == job_r.len) begin
          day_nxt = DAY_W'(1);
          rel_nxt = REL_NEXT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && is_last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
      n_r   <= '0;
      wk_r  <= '0;
      if (job.col == '0) begin
        day_r <= DAY_W'(1);
        rel_r <= REL_CUR;
      end else begin
        day_r <= job.prev_len - {2'b0, job.col} + DAY_W'(1);
        rel_r <= REL_PREV;
      end
    end else if (emit) begin
      n_r   <= n_r + CELL_W'(1);
      wk_r  <= (wk_r == LAST_COL) ? '0 : wk_r + COL_W'(1);
      day_r <= day_nxt;
      rel_r <= rel_nxt;
    end
    if (emit) begin
      o_idx_r   <= n_r;
      o_day_r   <= day_r;
      o_month_r <= cell_month;
      o_year_r  <= cell_year;
      o_rel_r   <= rel_r;
      o_last_r  <= is_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b0, o_year_r, o_month_r, o_day_r, o_idx_r};
  assign out_tuser  = o_rel_r;
  assign out_tlast  = o_last_r;

  `MCGG_ASSERT_SAME(a_idx_range, clk, rst_n, out_tvalid_r, o_idx_r <= CELL_W'(41))
  `MCGG_ASSERT_SAME(a_last_row_end, clk, rst_n, out_tvalid_r && o_last_r, o_idx_r == CELL_W'(27) || o_idx_r == CELL_W'(34) || o_idx_r == CELL_W'(41))
  `MCGG_ASSERT_SAME(a_prev_first_row, clk, rst_n, out_tvalid_r && o_rel_r == REL_PREV, o_idx_r < CELL_W'(6))

endmodule

// ----- rtl/month_calendar_grid_generator.sv -----
// channel | dir | tvalid/tready         | payload
// in      | in  | in_tvalid, in_tready  | in_tdata: month[3:0], year[17:4]
// out     | out | out_tvalid, out_tready| out_tdata: cell_index[5:0], day[10:6],
//         |     |                       |   cell_month[14:11], cell_year[28:15];
//         |     |                       | out_tuser: relation[1:0]; out_tlast: last
// A request goes through the front weekday/leap sequencer, then waits in the queue.
// The back emits one cell per cycle unless the output stalls: 28 to 42 cells per request.
// Throughput is set by the back, which loads a new request only after its last cell.
// Reset is synchronous, active low, and empties front, queue and output register.
// A stalled output holds the back; the front keeps accepting until the queue fills.
module month_calendar_grid_generator #(
  parameter int QDEPTH = mcgg_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mcgg_pkg::IN_DATA_W-1:0]   in_tdata,   // month[3:0], year[17:4]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mcgg_pkg::OUT_DATA_W-1:0]  out_tdata,  // cell_index, day, cell_month, cell_year
  output logic [mcgg_pkg::REL_W-1:0]       out_tuser,  // relation
  output logic                             out_tlast
);
  import mcgg_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  mcgg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_month   (in_tdata[MONTH_W-1:0]),
    .in_year    (in_tdata[MONTH_W+YEAR_W-1:MONTH_W]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  mcgg_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  mcgg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (pop_valid),
    .job_ready  (pop_ready),
    .job        (pop_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/sv/tb_month_calendar_grid_generator.sv -----
`timescale 1ns / 1ps

class calendar_grid_scoreboard;

  typedef struct {
    logic [mcgg_pkg::CELL_W-1:0]  cell_index;
    logic [mcgg_pkg::DAY_W-1:0]   day;
    logic [mcgg_pkg::MONTH_W-1:0] cell_month;
    logic [mcgg_pkg::YEAR_W-1:0]  cell_year;
    logic [mcgg_pkg::REL_W-1:0]   relation;
    logic                         is_last;
  } grid_cell_t;

  grid_cell_t expected_cells[$];
  int         error_count;
  int         weekday_shift[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
  int         plain_days[12]    = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  function new();
    error_count = 0;
  endfunction

  function int pending();
    return expected_cells.size();
  endfunction

  function int days_in_month(int m, int y);
    bit leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    if (m == 1) return leap ? 29 : 28;
    return plain_days[m];
  endfunction

  function void add_cell(int n, int day, int m, int y, logic [mcgg_pkg::REL_W-1:0] rel,
                         int total);
    grid_cell_t c;
    c.cell_index = n[mcgg_pkg::CELL_W-1:0];
    c.day        = day[mcgg_pkg::DAY_W-1:0];
    c.cell_month = m[mcgg_pkg::MONTH_W-1:0];
    c.cell_year  = y[mcgg_pkg::YEAR_W-1:0];
    c.relation   = rel;
    c.is_last    = (n == total - 1);
    expected_cells.push_back(c);
  endfunction

  function void note_request(logic [mcgg_pkg::MONTH_W-1:0] month_in,
                             logic [mcgg_pkg::YEAR_W-1:0] year_in);
    int m, y, yy, col, len, pm, py, nm, ny, plen, total, n, d;
    m = int'(month_in);
    if (m > int'(mcgg_pkg::MONTH_DEC)) m = int'(mcgg_pkg::MONTH_DEC);
    y = int'(year_in);
    yy = y + 400 - ((m < 2) ? 1 : 0);
    col = ((yy + yy / 4 - yy / 100 + yy / 400 + weekday_shift[m] + 1) % 7 + 6) % 7;
    len = days_in_month(m, y);
    pm = (m == 0) ? 11 : m - 1;
    py = (m == 0) ? ((y - 1) & 'h3FFF) : y;
    nm = (m == 11) ? 0 : m + 1;
    ny = (m == 11) ? ((y + 1) & 'h3FFF) : y;
    plen = days_in_month(pm, py);
    total = ((col + len + 6) / 7) * 7;
    if (total > 42) total = 42;
    n = 0;
    for (int i = 0; i < col; i++) begin
      add_cell(n, plen - col + 1 + i, pm, py, mcgg_pkg::REL_PREV, total);
      n++;
    end
    for (d = 1; d <= len; d++) begin
      add_cell(n, d, m, y, mcgg_pkg::REL_CUR, total);
      n++;
    end
    d = 1;
    while (n < total) begin
      add_cell(n, d, nm, ny, mcgg_pkg::REL_NEXT, total);
      n++;
      d++;
    end
  endfunction

  function void check_cell(logic [mcgg_pkg::OUT_DATA_W-1:0] data,
                           logic [mcgg_pkg::REL_W-1:0] user, logic tlast);
    grid_cell_t e;
    if (expected_cells.size() == 0) begin
      $display("%0t: unexpected cell tdata=%h tuser=%0d tlast=%0d", $time, data, user, tlast);
      error_count++;
      return;
    end
    e = expected_cells.pop_front();
    if (data[5:0] !== e.cell_index) begin
      $display("%0t: cell_index exp %0d act %0d", $time, e.cell_index, data[5:0]);
      error_count++;
    end
    if (data[10:6] !== e.day) begin
      $display("%0t: day exp %0d act %0d (cell %0d)", $time, e.day, data[10:6], e.cell_index);
      error_count++;
    end
    if (data[14:11] !== e.cell_month) begin
      $display("%0t: cell_month exp %0d act %0d (cell %0d)", $time, e.cell_month,
               data[14:11], e.cell_index);
      error_count++;
    end
    if (data[28:15] !== e.cell_year) begin
      $display("%0t: cell_year exp %0d act %0d (cell %0d)", $time, e.cell_year,
               data[28:15], e.cell_index);
      error_count++;
    end
    if (user !== e.relation) begin
      $display("%0t: relation exp %0d act %0d (cell %0d)", $time, e.relation, user,
               e.cell_index);
      error_count++;
    end
    if (tlast !== e.is_last) begin
      $display("%0t: last exp %0d act %0d (cell %0d)", $time, e.is_last, tlast, e.cell_index);
      error_count++;
    end
  endfunction

endclass

module tb_month_calendar_grid_generator;

  localparam int CYCLE_LIMIT = 1500000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [mcgg_pkg::IN_DATA_W-1:0]    in_tdata = '0;   // month[3:0], year[17:4]
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [mcgg_pkg::OUT_DATA_W-1:0]   out_tdata;       // cell_index, day, cell_month, cell_year
  logic [mcgg_pkg::REL_W-1:0]        out_tuser;       // relation
  logic                              out_tlast;

  calendar_grid_scoreboard grid_sb = new();

  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_hold  = 0;
  int rx_pause;
  int cycle_count = 0;

  month_calendar_grid_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold    <= 0;
    end else if (out_tvalid && out_tready) begin
      grid_sb.check_cell(out_tdata, out_tuser, out_tlast);
      rx_pause = rx_quiet ? 0 : $urandom_range(0, 12);
      if (rx_pause == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        rx_hold    <= rx_pause;
      end
    end else if (rx_hold > 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= (rx_hold == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_request(logic [mcgg_pkg::MONTH_W-1:0] month,
                              logic [mcgg_pkg::YEAR_W-1:0] year);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(mcgg_pkg::IN_DATA_W - mcgg_pkg::YEAR_W - mcgg_pkg::MONTH_W){1'b0}},
                  year, month};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    grid_sb.note_request(month, year);
  endtask

  task automatic wait_for_grid_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (grid_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    int pick;
    logic [mcgg_pkg::YEAR_W-1:0] edge_years[8] = '{
      14'd0, 14'd1, 14'd100, 14'd400, 14'd1900, 14'd2000, 14'd9999, 14'd16383};
    pick = $urandom_range(0, 99);
    if (pick < 85)
      send_request(4'($urandom_range(0, 11)), 14'($urandom_range(1, 9999)));
    else if (pick < 95)
      send_request(4'($urandom_range(0, 15)), 14'($urandom_range(0, 16383)));
    else
      send_request(4'($urandom_range(0, 15)), edge_years[$urandom_range(0, 7)]);
  endtask

  initial begin
    logic [mcgg_pkg::MONTH_W-1:0] dir_month[24] = '{
      4'd0, 4'd1, 4'd11, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd3, 4'd4,
      4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15, 4'd2};
    logic [mcgg_pkg::YEAR_W-1:0] dir_year[24] = '{
      14'd0, 14'd0, 14'd16383, 14'd1, 14'd2024, 14'd1900, 14'd2000, 14'd2023, 14'd2021,
      14'd2020, 14'd9999, 14'd1, 14'd1582, 14'd8192, 14'd4096, 14'd2730, 14'd5461,
      14'd1999, 14'd9999, 14'd0, 14'd16383, 14'd10922, 14'd5, 14'd2026};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 24; i++) send_request(dir_month[i], dir_year[i]);
    wait_for_grid_drain();

    for (int i = 0; i < 480; i++) begin
      if (i % 40 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      if (i % 120 == 119) wait_for_grid_drain();
      send_random_request();
    end

    wait_for_grid_drain();
    repeat (60) @(posedge clk);

    if (grid_sb.pending() != 0) begin
      $display("%0t: %0d expected cells never arrived", $time, grid_sb.pending());
      grid_sb.error_count++;
    end
    if (grid_sb.error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mcgg_pkg.sv
rtl/mcgg_front.sv
rtl/mcgg_queue.sv
rtl/mcgg_back.sv
rtl/month_calendar_grid_generator.sv
tb/sv/tb_month_calendar_grid_generator.sv
